// ===== sv/sector_cache_fifo_lookup_assert.svh =====
// ----------------------------------------------------------------------------
// Sector cache lookup assertion macros
// Concurrent assertion wrappers; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef SECTOR_CACHE_FIFO_LOOKUP_ASSERT_SVH
`define SECTOR_CACHE_FIFO_LOOKUP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is low.
`define SCFL_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is low.
`define SCFL_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SCFL_ASSERT_SAME(label, clk, rstn, ante, cons, msg)
`define SCFL_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== sv/scfl_pkg.sv =====
// ----------------------------------------------------------------------------
// Sector cache lookup package
// Shared constants, register indexes and types of the sector cache lookup.
// ----------------------------------------------------------------------------
package scfl_pkg;

    localparam int MAX_ENTRIES_DEF = 128;
    localparam int MIN_ENTRIES     = 4;

    // Field widths.
    localparam int INDEX_W   = 32;
    localparam int ENTRIES_W = 8;
    localparam int OFFSET_W  = 32;
    localparam int SBYTES_W  = 13;
    localparam int SLOT_W    = 7;
    localparam int BUFOFF_W  = 19;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 64;

    // Register reset values.
    localparam logic [ENTRIES_W-1:0] ENTRIES_RST = 8'd4;
    localparam logic [OFFSET_W-1:0]  OFFSET_RST  = 32'd0;
    localparam logic [SBYTES_W-1:0]  SBYTES_RST  = 13'd512;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENTRIES_IN_USE = 2'd0,
        CFG_START_OFFSET   = 2'd1,
        CFG_SECTOR_BYTES   = 2'd2
    } cfg_index_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    // Control part of the probe that walks along the cell chain.
    typedef struct packed {
        logic valid;
        logic found;
    } probe_ctl_t;

endpackage

// ===== sv/scfl_cell.sv =====
// ----------------------------------------------------------------------------
// Sector cache lookup cell
// Holds one slot tag and valid bit, compares the passing probe against it
// and hands the probe to the next cell every cycle.
// ----------------------------------------------------------------------------
module scfl_cell #(
    parameter int IDX_W   = 7,
    parameter int CELL_ID = 0
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              active,
    input  scfl_pkg::probe_ctl_t              ctl_in,
    input  logic [scfl_pkg::INDEX_W-1:0]      tag_in,
    input  logic [IDX_W-1:0]                  idx_in,
    output scfl_pkg::probe_ctl_t              ctl_out,
    output logic [scfl_pkg::INDEX_W-1:0]      tag_out,
    output logic [IDX_W-1:0]                  idx_out,
    input  logic                              wr_en,
    input  logic [IDX_W-1:0]                  wr_slot,
    input  logic [scfl_pkg::INDEX_W-1:0]      wr_tag
);

    localparam logic [IDX_W-1:0] MY_ID = IDX_W'(CELL_ID);

    logic [scfl_pkg::INDEX_W-1:0] slot_tag_reg;
    logic                         slot_valid_reg;
    scfl_pkg::probe_ctl_t         ctl_reg;
    logic [scfl_pkg::INDEX_W-1:0] tag_reg;
    logic [IDX_W-1:0]             idx_reg;
    logic                         match;
    logic                         write_here;

    assign write_here = wr_en && (wr_slot == MY_ID);

    // Only the first matching slot claims the probe.
    assign match = ctl_in.valid && !ctl_in.found && active && slot_valid_reg
                   && (slot_tag_reg == tag_in);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_valid_reg <= 1'b0;
            ctl_reg        <= '0;
        end else begin
            if (write_here) begin
                slot_valid_reg <= 1'b1;
            end
            ctl_reg.valid <= ctl_in.valid;
            ctl_reg.found <= ctl_in.found | match;
        end
    end

    always_ff @(posedge aclk) begin
        if (write_here) begin
            slot_tag_reg <= wr_tag;
        end
        tag_reg <= tag_in;
        idx_reg <= match ? MY_ID : idx_in;
    end

    assign ctl_out = ctl_reg;
    assign tag_out = tag_reg;
    assign idx_out = idx_reg;

endmodule

// ===== sv/sector_cache_fifo_lookup.sv =====
// The probe walks the cell chain at one cell per cycle. Only one lookup
// is in flight at a time: a new request is taken only in the idle state.
// Reset (aresetn low, synchronous) clears all slot valid bits, the victim
// pointer and the output valid flag, and restores the configuration defaults.
// ----------------------------------------------------------------------------
// Sector cache lookup top level
// Fully associative tag lookup with round-robin replacement over a chain
// of tag cells.
// ----------------------------------------------------------------------------
`include "sector_cache_fifo_lookup_assert.svh"

module sector_cache_fifo_lookup #(
    parameter int MAX_ENTRIES = scfl_pkg::MAX_ENTRIES_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Configuration write port.
    input  logic                               cfg_wen,
    input  logic [scfl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [scfl_pkg::CFG_DAT_W-1:0]     cfg_wdata,
    // Request channel.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [scfl_pkg::IN_DATA_W-1:0]     s_tdata,  // [31:0] sector_index
    // Result channel.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [0] hit, [7:1] slot, [26:8] buffer_offset, [27] fetch_request,
    // [59:28] fetch_sector, [63:60] zero
    output logic [scfl_pkg::OUT_DATA_W-1:0]    m_tdata
);

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (CNT_W > scfl_pkg::ENTRIES_W) ? CNT_W : scfl_pkg::ENTRIES_W;
    localparam int PROD_W = IDX_W + scfl_pkg::BUFOFF_W;
    localparam int EXT_W  = IDX_W + scfl_pkg::SLOT_W;

    // Configuration registers.
    logic [scfl_pkg::ENTRIES_W-1:0] entries_reg;
    logic [scfl_pkg::OFFSET_W-1:0]  start_offset_reg;
    logic [scfl_pkg::SBYTES_W-1:0]  sector_bytes_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entries_reg      <= scfl_pkg::ENTRIES_RST;
            start_offset_reg <= scfl_pkg::OFFSET_RST;
            sector_bytes_reg <= scfl_pkg::SBYTES_RST;
        end else if (cfg_wen) begin
            case (cfg_index)
                scfl_pkg::CFG_ENTRIES_IN_USE: begin
                    entries_reg <= cfg_wdata[scfl_pkg::ENTRIES_W-1:0];
                end
                scfl_pkg::CFG_START_OFFSET: begin
                    start_offset_reg <= cfg_wdata[scfl_pkg::OFFSET_W-1:0];
                end
                scfl_pkg::CFG_SECTOR_BYTES: begin
                    sector_bytes_reg <= cfg_wdata[scfl_pkg::SBYTES_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Effective entry count, clamped to MIN_ENTRIES..MAX_ENTRIES.
    logic [CMP_W-1:0] entries_ext;
    logic [CNT_W-1:0] eff_count;

    assign entries_ext = CMP_W'(entries_reg);

    always_comb begin
        if (entries_ext < CMP_W'(scfl_pkg::MIN_ENTRIES)) begin
            eff_count = CNT_W'(scfl_pkg::MIN_ENTRIES);
        end else if (entries_ext > CMP_W'(MAX_ENTRIES)) begin
            eff_count = CNT_W'(MAX_ENTRIES);
        end else begin
            eff_count = entries_ext[CNT_W-1:0];
        end
    end

    // Controller state.
    scfl_pkg::state_t state_reg, state_next;
    logic [IDX_W-1:0] victim_reg, victim_next;
    logic             res_found_reg;
    logic [IDX_W-1:0] res_idx_reg;
    logic [scfl_pkg::INDEX_W-1:0] res_tag_reg;
    logic             m_valid_reg;
    logic [scfl_pkg::OUT_DATA_W-1:0] m_data_reg;

    logic in_fire;
    logic finish_fire;

    // Cell chain wiring.
    scfl_pkg::probe_ctl_t         ctl_chain [0:MAX_ENTRIES];
    logic [scfl_pkg::INDEX_W-1:0] tag_chain [0:MAX_ENTRIES];
    logic [IDX_W-1:0]             idx_chain [0:MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0]       cell_active;
    logic [MAX_ENTRIES-1:0]       chain_valid;

    logic             wr_en;
    logic [IDX_W-1:0] chosen;

    assign s_tready    = (state_reg == scfl_pkg::ST_IDLE);
    assign in_fire     = s_tvalid && s_tready;
    assign finish_fire = (state_reg == scfl_pkg::ST_FINISH) && (!m_valid_reg || m_tready);

    assign ctl_chain[0].valid = in_fire;
    assign ctl_chain[0].found = 1'b0;
    assign tag_chain[0]       = s_tdata[scfl_pkg::INDEX_W-1:0];
    assign idx_chain[0]       = '0;

    for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
        assign cell_active[i] = eff_count > CNT_W'(i);
        assign chain_valid[i] = ctl_chain[i+1].valid;

        scfl_cell #(
            .IDX_W   (IDX_W),
            .CELL_ID (i)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .active  (cell_active[i]),
            .ctl_in  (ctl_chain[i]),
            .tag_in  (tag_chain[i]),
            .idx_in  (idx_chain[i]),
            .ctl_out (ctl_chain[i+1]),
            .tag_out (tag_chain[i+1]),
            .idx_out (idx_chain[i+1]),
            .wr_en   (wr_en),
            .wr_slot (chosen),
            .wr_tag  (res_tag_reg)
        );
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            scfl_pkg::ST_IDLE: begin
                if (in_fire) begin
                    state_next = scfl_pkg::ST_SEARCH;
                end
            end
            scfl_pkg::ST_SEARCH: begin
                if (ctl_chain[MAX_ENTRIES].valid) begin
                    state_next = scfl_pkg::ST_FINISH;
                end
            end
            scfl_pkg::ST_FINISH: begin
                if (finish_fire) begin
                    state_next = scfl_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = scfl_pkg::ST_IDLE;
            end
        endcase
    end

    // Victim choice: a pointer left beyond the count falls back to slot 0.
    logic [IDX_W-1:0] victim_slot;
    logic [CNT_W-1:0] victim_inc;

    assign victim_slot = (CNT_W'(victim_reg) < eff_count) ? victim_reg : '0;
    assign victim_inc  = CNT_W'(victim_slot) + CNT_W'(1);
    assign victim_next = (victim_inc >= eff_count) ? '0 : victim_inc[IDX_W-1:0];
    assign chosen      = res_found_reg ? res_idx_reg : victim_slot;
    assign wr_en       = finish_fire && !res_found_reg;

    // Result fields.
    logic [EXT_W-1:0]                 chosen_ext;
    logic [PROD_W-1:0]                offset_prod;
    logic [scfl_pkg::OFFSET_W-1:0]    fetch_sum;
    logic [scfl_pkg::OUT_DATA_W-1:0]  result;

    assign chosen_ext  = EXT_W'(chosen);
    assign offset_prod = PROD_W'(chosen) * PROD_W'(sector_bytes_reg);
    assign fetch_sum   = res_found_reg ? '0 : (res_tag_reg + start_offset_reg);

    assign result = {4'b0000,
                     fetch_sum,
                     !res_found_reg,
                     offset_prod[scfl_pkg::BUFOFF_W-1:0],
                     chosen_ext[scfl_pkg::SLOT_W-1:0],
                     res_found_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= scfl_pkg::ST_IDLE;
            victim_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (wr_en) begin
                victim_reg <= victim_next;
            end
            if (finish_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == scfl_pkg::ST_SEARCH) && ctl_chain[MAX_ENTRIES].valid) begin
            res_found_reg <= ctl_chain[MAX_ENTRIES].found;
            res_idx_reg   <= idx_chain[MAX_ENTRIES];
            res_tag_reg   <= tag_chain[MAX_ENTRIES];
        end
        if (finish_fire) begin
            m_data_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Short names for the checks below.
    logic             tail_valid;
    logic             in_search;
    logic             in_idle;
    logic [CNT_W-1:0] victim_ext;

    assign tail_valid = ctl_chain[MAX_ENTRIES].valid;
    assign in_search  = (state_reg == scfl_pkg::ST_SEARCH);
    assign in_idle    = (state_reg == scfl_pkg::ST_IDLE);
    assign victim_ext = CNT_W'(victim_reg);

    // At most one probe is in the chain at any time.
    `SCFL_ASSERT_SAME(a_one_probe, aclk, aresetn, 1'b1, $onehot0(chain_valid), "two probes")
    // A probe leaves the chain only while the controller is searching.
    `SCFL_ASSERT_SAME(a_tail, aclk, aresetn, tail_valid, in_search, "probe out of search")
    // After a replacement the victim pointer lies below the entry count.
    `SCFL_ASSERT_NEXT(a_victim, aclk, aresetn, wr_en, victim_ext < $past(eff_count), "bad victim")
    // A finished lookup is always presented on the result channel.
    `SCFL_ASSERT_NEXT(a_result, aclk, aresetn, finish_fire, m_tvalid && in_idle, "result lost")

endmodule
